// File: rtl/lca_pkg.sv
package lca_pkg;

  // payload widths
  localparam int SAMPLE_W   = 16;
  localparam int LSIZE_W    = 7;
  localparam int SWEEPS_W   = 16;
  localparam int LAG_OUT_W  = 6;
  localparam int RES_W      = 32;
  localparam int SUM_W      = 48;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  // serial divider step counter
  localparam int DIV_CNT_W = $clog2(SUM_W + 1);

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_LATTICE_SIZE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_SWEEPS   = 8'd1;

  // control broadcast to every cell of the row
  typedef struct packed {
    logic rot;   // rotate the site ring by one
    logic mac;   // accumulate head * own site
    logic clr;   // clear the lag accumulator
    logic adv;   // shift results one cell toward the head
  } cell_ctrl_t;

endpackage

// File: rtl/lca_in_if.sv
interface lca_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [lca_pkg::SAMPLE_W-1:0]   sample;
  logic                                  last_sample;

  modport source (output valid, sample, last_sample, input ready);
  modport sink   (input valid, sample, last_sample, output ready);
endinterface

// File: rtl/lca_out_if.sv
interface lca_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [lca_pkg::LAG_OUT_W-1:0]        lag;
  logic signed [lca_pkg::RES_W-1:0]     correlator;
  logic signed [lca_pkg::RES_W-1:0]     running_mean;
  logic                                 last_lag;

  modport source (output valid, lag, correlator, running_mean, last_lag, input ready);
  modport sink   (input valid, lag, correlator, running_mean, last_lag, output ready);
endinterface

// File: rtl/lca_cfg_if.sv
interface lca_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [lca_pkg::CFG_IDX_W-1:0]     index;
  logic [lca_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/lca_cell.sv
module lca_cell #(
  parameter int ACC_W = 38
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  lca_pkg::cell_ctrl_t                 ctrl,
  input  logic                                wr_en,
  input  logic                                in_ring,
  input  logic                                is_end,
  input  logic signed [lca_pkg::SAMPLE_W-1:0] sample,
  input  logic signed [lca_pkg::SAMPLE_W-1:0] head,
  input  logic signed [lca_pkg::SAMPLE_W-1:0] nb_site,
  input  logic signed [ACC_W-1:0]             nb_acc,
  input  logic signed [lca_pkg::SUM_W-1:0]    nb_sum,
  input  logic signed [lca_pkg::SUM_W-1:0]    new_sum,
  output logic signed [lca_pkg::SAMPLE_W-1:0] site,
  output logic signed [ACC_W-1:0]             acc,
  output logic signed [lca_pkg::SUM_W-1:0]    sum
);

  logic signed [lca_pkg::SAMPLE_W-1:0]   site_r;
  logic signed [ACC_W-1:0]               acc_r;
  logic signed [lca_pkg::SUM_W-1:0]      sum_r;
  logic signed [2*lca_pkg::SAMPLE_W-1:0] prod;

  assign prod = head * site_r;

  // site value: loaded from the input, rotated around the active ring
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      site_r <= '0;
    end else if (wr_en) begin
      site_r <= sample;
    end else if (ctrl.rot && in_ring) begin
      site_r <= is_end ? head : nb_site;
    end
  end

  // lag accumulator, shifted toward the head once results are read
  always_ff @(posedge clk) begin
    if (ctrl.clr) begin
      acc_r <= '0;
    end else if (ctrl.mac) begin
      acc_r <= acc_r + {{(ACC_W-2*lca_pkg::SAMPLE_W){prod[2*lca_pkg::SAMPLE_W-1]}}, prod};
    end else if (ctrl.adv) begin
      acc_r <= nb_acc;
    end
  end

  // running lag sum, rotated so the head always holds the current lag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (ctrl.adv && in_ring) begin
      sum_r <= is_end ? new_sum : nb_sum;
    end
  end

  assign site = site_r;
  assign acc  = acc_r;
  assign sum  = sum_r;

endmodule

// File: rtl/lca_div.sv
module lca_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [lca_pkg::SUM_W-1:0]         dividend,
  input  logic [lca_pkg::SWEEPS_W-1:0]      divisor,
  output logic                              done,
  output logic [lca_pkg::SUM_W-1:0]         quotient
);

  logic                               busy_r;
  logic                               done_r;
  logic [lca_pkg::DIV_CNT_W-1:0]      cnt_r;
  logic [lca_pkg::SWEEPS_W-1:0]       rem_r;
  logic [lca_pkg::SWEEPS_W-1:0]       rem_nxt;
  logic [lca_pkg::SWEEPS_W-1:0]       dsr_r;
  logic [lca_pkg::SUM_W-1:0]          quo_r;
  logic [lca_pkg::SUM_W-1:0]          quo_nxt;
  logic [lca_pkg::SWEEPS_W:0]         trial;
  logic [lca_pkg::SWEEPS_W+1:0]       diff;

  // one restoring step: shift in next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem_r, quo_r[lca_pkg::SUM_W-1]};
    diff  = {1'b0, trial} - {2'b00, dsr_r};
    if (!diff[lca_pkg::SWEEPS_W+1]) begin
      rem_nxt = diff[lca_pkg::SWEEPS_W-1:0];
      quo_nxt = {quo_r[lca_pkg::SUM_W-2:0], 1'b1};
    end else begin
      rem_nxt = trial[lca_pkg::SWEEPS_W-1:0];
      quo_nxt = {quo_r[lca_pkg::SUM_W-2:0], 1'b0};
    end
  end

  // step control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= lca_pkg::DIV_CNT_W'(lca_pkg::SUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - lca_pkg::DIV_CNT_W'(1);
        if (cnt_r == lca_pkg::DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// File: rtl/lattice_circular_autocorrelation.sv
// channel  dir  handshake       word
// in_ch    in   valid / ready   sample (s16 Q8.8), last_sample
// out_ch   out  valid / ready   lag, correlator, running_mean (s32 Q16.16), last_lag
// cfg_ch   in   valid / ready   index (0 lattice_size, 1 num_sweeps), data
//
// samples are accepted one per cycle while idle; the one marked last starts multiply-accumulate
// on the row of cells (one MAC per lag), then each lag passes twice through the shared
// 1-bit-per-cycle divider (two 48-step divisions) before its word is offered on out_ch.
// synchronous reset clears the site store, lag sums and control/config registers, not the results.
// in_ch is stalled from the last sample until the final lag word is taken;
// out_ch back-pressure holds the result register and the sequencer.
module lattice_circular_autocorrelation #(
  parameter int MAX_SITES = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  lca_in_if.sink    in_ch,
  lca_out_if.source out_ch,
  lca_cfg_if.sink   cfg_ch
);

  localparam int CNT_W = $clog2(MAX_SITES + 1);
  localparam int LAG_W = $clog2(MAX_SITES);
  localparam int ACC_W = 2 * lca_pkg::SAMPLE_W + $clog2(MAX_SITES);
  localparam int SW    = lca_pkg::SUM_W;
  localparam int RW    = lca_pkg::RES_W;
  localparam logic [lca_pkg::LSIZE_W-1:0] MAX_N = lca_pkg::LSIZE_W'(MAX_SITES);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MAC  = 3'd1;
  localparam logic [2:0] S_D1GO = 3'd2;
  localparam logic [2:0] S_D1   = 3'd3;
  localparam logic [2:0] S_D2GO = 3'd4;
  localparam logic [2:0] S_D2   = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0]                       st_r;
  logic [2:0]                       st_nxt;
  logic [lca_pkg::LSIZE_W-1:0]      lattice_size_r;
  logic [lca_pkg::SWEEPS_W-1:0]     num_sweeps_r;
  logic [lca_pkg::SWEEPS_W-1:0]     ns_eff;
  logic [lca_pkg::LSIZE_W-1:0]      n7;
  logic [CNT_W-1:0]                 n_cfg;
  logic [CNT_W-1:0]                 n_r;
  logic [CNT_W-1:0]                 cnt_r;
  logic [CNT_W-1:0]                 step_r;
  logic [LAG_W-1:0]                 lag_r;
  logic                             last_lag;
  logic                             sign_r;
  logic signed [RW-1:0]             corr_r;
  logic signed [RW-1:0]             mean_r;
  logic signed [SW-1:0]             sum_r;
  logic                             in_acc;
  logic                             out_acc;
  lca_pkg::cell_ctrl_t              ctrl;

  logic signed [lca_pkg::SAMPLE_W-1:0] site_w [0:MAX_SITES];
  logic signed [ACC_W-1:0]             acc_w  [0:MAX_SITES];
  logic signed [SW-1:0]                sum_w  [0:MAX_SITES];

  logic              acc_neg;
  logic [ACC_W-1:0]  acc_mag;
  logic [SW-1:0]     sum_mag;
  logic              div_start;
  logic              div_done;
  logic [SW-1:0]     div_dividend;
  logic [lca_pkg::SWEEPS_W-1:0] div_divisor;
  logic [SW-1:0]     quo;
  logic signed [SW:0] q_s;
  logic signed [RW-1:0] q_sat;
  logic signed [SW:0] sum_wide;
  logic signed [SW-1:0] sum_sat;

  // saturate a 49-bit signed value to 32 bits
  function automatic logic signed [RW-1:0] sat32(input logic signed [SW:0] v);
    logic signed [RW-1:0] r;
    if (!v[SW] && (|v[SW-1:RW-1])) begin
      r = {1'b0, {(RW-1){1'b1}}};
    end else if (v[SW] && !(&v[SW-1:RW-1])) begin
      r = {1'b1, {(RW-1){1'b0}}};
    end else begin
      r = v[RW-1:0];
    end
    return r;
  endfunction

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;

  // configuration registers
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lattice_size_r <= lca_pkg::LSIZE_W'(64);
      num_sweeps_r   <= lca_pkg::SWEEPS_W'(1);
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        lca_pkg::REG_LATTICE_SIZE: lattice_size_r <= cfg_ch.data[lca_pkg::LSIZE_W-1:0];
        lca_pkg::REG_NUM_SWEEPS:   num_sweeps_r   <= cfg_ch.data[lca_pkg::SWEEPS_W-1:0];
        default: ;
      endcase
    end
  end

  // effective lattice size and divisor
  always_comb begin
    if (lattice_size_r < lca_pkg::LSIZE_W'(2)) begin
      n7 = lca_pkg::LSIZE_W'(2);
    end else if (lattice_size_r > MAX_N) begin
      n7 = MAX_N;
    end else begin
      n7 = lattice_size_r;
    end
    n_cfg  = CNT_W'(n7);
    ns_eff = (num_sweeps_r == '0) ? lca_pkg::SWEEPS_W'(1) : num_sweeps_r;
  end

  // cell row control
  always_comb begin
    ctrl.rot = (st_r == S_MAC);
    ctrl.mac = (st_r == S_MAC);
    ctrl.clr = in_acc && in_ch.last_sample;
    ctrl.adv = out_acc;
  end

  assign site_w[MAX_SITES] = '0;
  assign acc_w[MAX_SITES]  = '0;
  assign sum_w[MAX_SITES]  = '0;

  // row of cells, cell k holds site k and the results of lag k
  for (genvar k = 0; k < MAX_SITES; k++) begin : g_cell
    lca_cell #(.ACC_W(ACC_W)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (ctrl),
      .wr_en   (in_acc && (cnt_r == CNT_W'(k)) && (cnt_r < n_cfg)),
      .in_ring (CNT_W'(k) < n_r),
      .is_end  (CNT_W'(k) == (n_r - CNT_W'(1))),
      .sample  (in_ch.sample),
      .head    (site_w[0]),
      .nb_site (site_w[k+1]),
      .nb_acc  (acc_w[k+1]),
      .nb_sum  (sum_w[k+1]),
      .new_sum (sum_r),
      .site    (site_w[k]),
      .acc     (acc_w[k]),
      .sum     (sum_w[k])
    );
  end

  // shared divider: first |acc|/n, then |sum|/num_sweeps
  assign acc_neg      = acc_w[0][ACC_W-1];
  assign acc_mag      = acc_neg ? ACC_W'(-acc_w[0]) : ACC_W'(acc_w[0]);
  assign sum_mag      = sum_r[SW-1] ? SW'(-sum_r) : SW'(sum_r);
  assign div_start    = (st_r == S_D1GO) || (st_r == S_D2GO);
  assign div_dividend = (st_r == S_D1GO) ? SW'(acc_mag) : sum_mag;
  assign div_divisor  = (st_r == S_D1GO) ? lca_pkg::SWEEPS_W'(n_r) : ns_eff;

  lca_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (quo)
  );

  // signed quotient, saturated sum update
  always_comb begin
    q_s      = sign_r ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    q_sat    = sat32(q_s);
    sum_wide = {sum_w[0][SW-1], sum_w[0]} + {{(SW+1-RW){q_sat[RW-1]}}, q_sat};
    if (sum_wide[SW] != sum_wide[SW-1]) begin
      sum_sat = sum_wide[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end else begin
      sum_sat = sum_wide[SW-1:0];
    end
  end

  assign last_lag = (CNT_W'(lag_r) == (n_r - CNT_W'(1)));

  // sequencer next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: if (in_acc && in_ch.last_sample) st_nxt = S_MAC;
      S_MAC:  if (step_r == (n_r - CNT_W'(1))) st_nxt = S_D1GO;
      S_D1GO: st_nxt = S_D1;
      S_D1:   if (div_done) st_nxt = S_D2GO;
      S_D2GO: st_nxt = S_D2;
      S_D2:   if (div_done) st_nxt = S_OUT;
      S_OUT:  if (out_acc) st_nxt = last_lag ? S_IDLE : S_D1GO;
      default: st_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      cnt_r  <= '0;
      n_r    <= CNT_W'(2);
      step_r <= '0;
      lag_r  <= '0;
    end else begin
      st_r <= st_nxt;
      if (in_acc) begin
        if (in_ch.last_sample) begin
          cnt_r  <= '0;
          n_r    <= n_cfg;
          step_r <= '0;
        end else if (cnt_r < n_cfg) begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
      end
      if (st_r == S_MAC) begin
        step_r <= step_r + CNT_W'(1);
        lag_r  <= '0;
      end
      if (out_acc) begin
        lag_r <= lag_r + LAG_W'(1);
      end
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    case (st_r)
      S_D1GO: sign_r <= acc_neg;
      S_D1: begin
        if (div_done) begin
          corr_r <= q_sat;
          sum_r  <= sum_sat;
        end
      end
      S_D2GO: sign_r <= sum_r[SW-1];
      S_D2: begin
        if (div_done) begin
          mean_r <= q_sat;
        end
      end
      default: ;
    endcase
  end

  // ports
  assign in_ch.ready         = (st_r == S_IDLE);
  assign out_ch.valid        = (st_r == S_OUT);
  assign out_ch.lag          = lca_pkg::LAG_OUT_W'(lag_r);
  assign out_ch.correlator   = corr_r;
  assign out_ch.running_mean = mean_r;
  assign out_ch.last_lag     = last_lag;

endmodule
